### design/mad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_pkg
// Shared widths, register map and defaults of the moving average filter
// with output deadband.
// ---------------------------------------------------------------------------
package mad_pkg;

	// sample and average width
	localparam int SAMPLE_W = 12;

	// default averaging window
	localparam int WINDOW_DEF = 10;

	// configuration port
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_THRESHOLD = reg_idx_t'(0);

	// reset value of the change threshold
	localparam sample_t THRESH_RESET = sample_t'(50);

endpackage

### design/mad_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_cell
// One tap of the sample window: holds one sample and hands it on to the
// next cell whenever a new sample beat enters the window.
// ---------------------------------------------------------------------------
module mad_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  mad_pkg::sample_t d,
	output mad_pkg::sample_t q
);
	import mad_pkg::*;

	sample_t tap_q;

	// take the neighbor's sample on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

### design/mad_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_window
// Chain of sample cells holding the last WINDOW samples, plus the running
// sum: the new sample is added and the one falling off the chain subtracted.
// ---------------------------------------------------------------------------
module mad_window #(
	parameter int WINDOW = mad_pkg::WINDOW_DEF,
	parameter int SUM_W  = mad_pkg::SAMPLE_W + $clog2(mad_pkg::WINDOW_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  mad_pkg::sample_t in_sample,
	output logic             valid_s1,
	output logic [SUM_W-1:0] sum
);
	import mad_pkg::*;

	sample_t          tap [WINDOW];
	logic             shift;
	logic [SUM_W-1:0] sum_q;
	logic             valid_q;

	assign shift = adv && in_valid;

	// build the row of cells, newest sample enters cell zero
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		sample_t d;
		if (i == 0) begin : g_head
			assign d = in_sample;
		end else begin : g_link
			assign d = tap[i-1];
		end
		mad_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (d),
			.q     (tap[i])
		);
	end

	// update the running sum and the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
			if (in_valid) begin
				sum_q <= sum_q - SUM_W'(tap[WINDOW-1]) + SUM_W'(in_sample);
			end
		end
	end

	assign valid_s1 = valid_q;
	assign sum      = sum_q;

endmodule

### design/mad_recip_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_recip_div
// Divide the window sum by WINDOW with a registered multiply by a rounded-up
// reciprocal; the shift is wide enough that the quotient is exact.
// ---------------------------------------------------------------------------
module mad_recip_div #(
	parameter int WINDOW = mad_pkg::WINDOW_DEF,
	parameter int SUM_W  = mad_pkg::SAMPLE_W + $clog2(mad_pkg::WINDOW_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             valid_s1,
	input  logic [SUM_W-1:0] sum,
	output logic             valid_s2,
	output mad_pkg::sample_t quot
);
	import mad_pkg::*;

	localparam int SHIFT   = SUM_W + $clog2(WINDOW);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	logic [PROD_W-1:0] prod_s2;
	logic              valid_q;

	// register the valid of the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s1;
		end
	end

	// multiply by the reciprocal
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(sum) * PROD_W'(RECIP);
		end
	end

	assign valid_s2 = valid_q;
	assign quot     = prod_s2[SHIFT +: SAMPLE_W];

endmodule

### design/moving_average_deadband.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// moving_average_deadband
// Moving average of converter samples over a window, reported only when
// it moves by more than a programmable threshold.
// ---------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid / sample_stall / sample. A beat is taken
//   at each edge with sample_valid high and sample_stall low.
//   Average channel: average_valid / average_stall / average. A beat
//   carries a new window average; samples whose average stays within
//   change_threshold of the last reported one give no beat.
//   Path: a sample beat passes the window update, the reciprocal
//   multiply and the deadband compare and output register, each one
//   registered. Throughput: one sample per cycle while no stall freezes
//   the pipeline, set by the running sum update beside the cell chain.
//   Stall: while a held average is stalled, the whole pipeline freezes
//   and sample_stall is raised; otherwise samples flow every cycle.
//   Reset: all window cells, the sum and the last reported average clear
//   to zero and change_threshold returns to 50; samples are taken at once.
//   Config: APB register 0 (byte address 0) is change_threshold, 12 bits;
//   write it only while the block is idle.
// ---------------------------------------------------------------------------
module moving_average_deadband #(
	parameter int WINDOW = mad_pkg::WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  mad_pkg::sample_t             sample,
	// average channel
	output logic                         average_valid,
	input  logic                         average_stall,
	output mad_pkg::sample_t             average,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mad_pkg::PADDR_W-1:0]  paddr,
	input  logic [mad_pkg::PDATA_W-1:0]  pwdata,
	output logic [mad_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import mad_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

	logic             adv;
	logic             valid_s1;
	logic [SUM_W-1:0] sum;
	logic             valid_s2;
	sample_t          avg;
	sample_t          diff;
	logic             report;
	reg_idx_t         reg_idx;
	sample_t          thresh_q;
	sample_t          last_q;
	sample_t          avg_q;
	logic             avg_valid_q;

	// advance unless a held average is stalled
	assign adv          = !(avg_valid_q && average_stall);
	assign sample_stall = !adv;

	// configuration register
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_THRESHOLD) begin
			thresh_q <= pwdata[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_THRESHOLD) begin
			prdata = PDATA_W'(thresh_q);
		end
	end

	// window of cells and running sum
	mad_window #(
		.WINDOW(WINDOW),
		.SUM_W (SUM_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (sample_valid),
		.in_sample(sample),
		.valid_s1 (valid_s1),
		.sum      (sum)
	);

	// divide by the window length
	mad_recip_div #(
		.WINDOW(WINDOW),
		.SUM_W (SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_s1(valid_s1),
		.sum     (sum),
		.valid_s2(valid_s2),
		.quot    (avg)
	);

	// deadband: report only a change beyond the threshold
	assign diff   = (avg >= last_q) ? (avg - last_q) : (last_q - avg);
	assign report = valid_s2 && (diff > thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			avg_valid_q <= 1'b0;
		end else if (adv) begin
			avg_valid_q <= report;
			if (report) begin
				last_q <= avg;
			end
		end
	end

	// hold the reported average for the output beat
	always_ff @(posedge clk) begin
		if (adv && report) begin
			avg_q <= avg;
		end
	end

	assign average_valid = avg_valid_q;
	assign average       = avg_q;

endmodule

### tb/mad_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_checker
// Watches the sample, average and register channels of the moving average
// filter, predicts every reported average and compares it with the block.
// ---------------------------------------------------------------------------
module mad_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	input  logic                         sample_stall,
	input  mad_pkg::sample_t             sample,
	input  logic                         average_valid,
	input  logic                         average_stall,
	input  mad_pkg::sample_t             average,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [mad_pkg::PADDR_W-1:0]  paddr,
	input  logic [mad_pkg::PDATA_W-1:0]  pwdata,
	output int                           pending,
	output int                           failures
);
	import mad_pkg::*;

	localparam int WIN      = WINDOW_DEF;
	localparam int SUM_W    = SAMPLE_W + $clog2(WIN);
	localparam int SHOW_MAX = 10;

	// predictor state
	sample_t          window_q [WIN];
	logic [SUM_W-1:0] run_sum;
	int unsigned      slot;
	sample_t          reported;
	sample_t          threshold;

	// averages predicted but not yet seen on the output
	sample_t          avg_queue [$];
	int               fail_count;

	initial begin
		pending  = 0;
		failures = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		sample_t got_exp;
		sample_t avg;
		sample_t gap;
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				window_q[k] = '0;
			end
			run_sum    = '0;
			slot       = 0;
			reported   = '0;
			threshold  = THRESH_RESET;
			fail_count = 0;
			avg_queue.delete();
		end else begin
			// compare an output beat with the oldest prediction
			if (average_valid && !average_stall) begin
				if (avg_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_MAX)
						$display("%0t: unexpected average %0d", $realtime, average);
				end else begin
					got_exp = avg_queue.pop_front();
					if (average !== got_exp) begin
						fail_count++;
						if (fail_count <= SHOW_MAX)
							$display("%0t: average expected %0d actual %0d",
								$realtime, got_exp, average);
					end
				end
			end

			// track threshold writes; other indexes are ignored
			if (psel && penable && pwrite && pready &&
					paddr[PADDR_W-1:2] == REG_THRESHOLD) begin
				threshold = pwdata[SAMPLE_W-1:0];
			end

			// advance the window on each sample beat
			if (sample_valid && !sample_stall) begin
				run_sum = run_sum - SUM_W'(window_q[slot]) + SUM_W'(sample);
				window_q[slot] = sample;
				slot = (slot == WIN - 1) ? 0 : slot + 1;
				avg = sample_t'(run_sum / WIN);
				gap = (avg >= reported) ? avg - reported : reported - avg;
				if (gap > threshold) begin
					avg_queue.push_back(avg);
					reported = avg;
				end
			end
		end
		pending  <= avg_queue.size();
		failures <= fail_count;
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds directed and random sample streams through the moving average
// filter under several deadband thresholds and idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
	import mad_pkg::*;

	localparam int       CYCLE_LIMIT  = 200000;
	localparam int       DRAIN_CYCLES = 10;
	localparam int       HOLD_CYCLES  = 300;
	localparam int       SEG_ITEMS    = 175;
	localparam int       SEG_COUNT    = 6;
	localparam reg_idx_t REG_SPARE    = reg_idx_t'(1);

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                sample_valid  = 1'b0;
	logic                sample_stall;
	sample_t             sample        = '0;
	logic                average_valid;
	logic                average_stall = 1'b0;
	sample_t             average;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [PADDR_W-1:0]  paddr         = '0;
	logic [PDATA_W-1:0]  pwdata        = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int pending;
	int failures;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycles        = 0;

	moving_average_deadband DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.average_valid (average_valid),
		.average_stall (average_stall),
		.average       (average),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	mad_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.average_valid (average_valid),
		.average_stall (average_stall),
		.average       (average),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pending       (pending),
		.failures      (failures)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			average_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served   <= hold_requests;
			hold_left     <= HOLD_CYCLES;
			average_stall <= 1'b1;
		end else begin
			average_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// offer one sample beat and hold it until taken
	task automatic put_sample(input int value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk) sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= sample_t'(value);
		do @(posedge clk); while (sample_stall);
	endtask

	// drop valid, wait for every predicted average, let the pipe empty
	task automatic drain();
		@(negedge clk) sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one burst: mostly steady levels with small noise, some random and rail values
	task automatic send_burst(inout int left);
		int kind;
		int len;
		int level;
		int v;
		kind  = $urandom_range(0, 9);
		len   = $urandom_range(1, 15);
		level = $urandom_range(0, 4095);
		for (int k = 0; k < len && left > 0; k++) begin
			if (kind < 6) begin
				v = level + $urandom_range(0, 6) - 3;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end else if (kind < 8) begin
				v = $urandom_range(0, 4095);
			end else begin
				v = $urandom_range(0, 1) ? 4095 : 0;
			end
			put_sample(v);
			left--;
		end
	endtask

	initial begin
		int      left;
		bit      held;
		sample_t thr;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// start-up from a zero window under the reset threshold, then a full-scale step
		put_sample(0);
		repeat (10) put_sample(4095);
		drain();

		// zero threshold with junk upper bits; a write to a spare index is ignored
		apb_write(REG_THRESHOLD, 32'hABCD_E000);
		apb_write(REG_SPARE, 32'h0000_0FFF);
		put_sample(4095);
		put_sample(4085);
		drain();

		// widest threshold: even a full-scale swing stays quiet
		apb_write(REG_THRESHOLD, 32'h0000_0FFF);
		repeat (10) put_sample(0);
		drain();

		// random segments over idling patterns and thresholds
		held = 1'b0;
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0:       thr = sample_t'(3);
				1:       thr = sample_t'($urandom_range(0, 200));
				2:       thr = THRESH_RESET;
				3:       thr = sample_t'($urandom_range(100, 1500));
				4:       thr = '0;
				default: thr = sample_t'($urandom_range(0, 4095));
			endcase
			apb_write(REG_THRESHOLD, {20'($urandom()), thr});
			left = SEG_ITEMS;
			while (left > 0) begin
				// hold off the receiver once while results stream in
				if (seg == 4 && !held && left <= SEG_ITEMS - 30) begin
					hold_requests++;
					held = 1'b1;
				end
				send_burst(left);
			end
			drain();
		end

		if (failures == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
design/mad_pkg.sv
design/mad_cell.sv
design/mad_window.sv
design/mad_recip_div.sv
design/moving_average_deadband.sv
tb/mad_checker.sv
tb/tb_top.sv
